>>> sv/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHECK_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("same-cycle check failed");
`define CHECK_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("next-cycle check failed");
`else
`define CHECK_IMP(label, pre, post)
`define CHECK_NEXT(label, pre, post)
`endif
`endif

>>> sv/stup_pkg.sv
// types, constants and helper functions of the string to integer parser
package stup_pkg;

   localparam int ConsumedWidth = 13;
   localparam int ValueWidth    = 64;
   localparam int BaseWidth     = 6;

   localparam logic [7:0] ChMinus   = 8'h2d;
   localparam logic [7:0] ChPlus    = 8'h2b;
   localparam logic [7:0] ChZero    = 8'h30;
   localparam logic [7:0] ChNine    = 8'h39;
   localparam logic [7:0] ChLowX    = 8'h78;
   localparam logic [7:0] ChUpX     = 8'h58;
   localparam logic [7:0] ChUpA     = 8'h41;
   localparam logic [7:0] ChUpZ     = 8'h5a;
   localparam logic [7:0] ChLowA    = 8'h61;
   localparam logic [7:0] ChLowZ    = 8'h7a;
   localparam logic [7:0] ChSpace   = 8'h20;
   localparam logic [7:0] ChTab     = 8'h09;
   localparam logic [7:0] ChCr      = 8'h0d;

   localparam logic [BaseWidth-1:0] BaseDetect = 6'd0;
   localparam logic [BaseWidth-1:0] BaseOne    = 6'd1;
   localparam logic [BaseWidth-1:0] BaseMin    = 6'd2;
   localparam logic [BaseWidth-1:0] BaseOct    = 6'd8;
   localparam logic [BaseWidth-1:0] BaseDec    = 6'd10;
   localparam logic [BaseWidth-1:0] BaseHex    = 6'd16;
   localparam logic [BaseWidth-1:0] BaseMax    = 6'd36;
   localparam logic [BaseWidth-1:0] NoDigit    = 6'd63;
   localparam logic [BaseWidth-1:0] LetterBias = 6'd10;

   typedef enum logic [5:0] {
      PH_WS    = 6'b000001,
      PH_FIRST = 6'b000010,
      PH_ZERO  = 6'b000100,
      PH_X     = 6'b001000,
      PH_DIG   = 6'b010000,
      PH_DONE  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [ValueWidth-1:0]    value;
      logic                     range_error;
      logic [ConsumedWidth-1:0] consumed;
   } rsp_type;

   typedef struct packed {
      phase_type             phase;
      logic [ValueWidth-1:0] acc;
      logic                  minus_seen;
      logic                  overflowed;
      logic [BaseWidth-1:0]  base_in_use;
   } parse_state_type;

   localparam parse_state_type IdleState = '{
      phase:       PH_WS,
      acc:         '0,
      minus_seen:  1'b0,
      overflowed:  1'b0,
      base_in_use: BaseDetect
   };

   function automatic logic [BaseWidth-1:0] digit_value(input logic [7:0] c);
      logic [BaseWidth-1:0] d;
      d = NoDigit;
      if (c >= ChZero && c <= ChNine) begin
         d = BaseWidth'(c - ChZero);
      end else if (c >= ChUpA && c <= ChUpZ) begin
         d = BaseWidth'(c - ChUpA) + LetterBias;
      end else if (c >= ChLowA && c <= ChLowZ) begin
         d = BaseWidth'(c - ChLowA) + LetterBias;
      end
      return d;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == ChSpace) || (c >= ChTab && c <= ChCr);
   endfunction

endpackage

>>> sv/string_to_unsigned_integer_parser.sv
// top level of the string to unsigned 64-bit integer parser
// Characters of one string arrive on the req_ channel, one per request, and
// req_payload.last marks the final one. csr_data sets the number base (0 to
// detect from a prefix, 2 to 36); it is taken up on the first character of
// each string. The user must write it only while no string is in flight;
// the block itself does not enforce this. Each accepted character is held
// in a request register; from there the parse step updates the string
// state and, for the final character, loads the result register that
// drives rsp_: the request register loads at the accepting edge, the result
// register at the edge on which that final character advances.
// One character is taken every cycle while req_stall is low: the only loop
// is the multiply-add of the accumulator by the base.
// While a result waits under rsp_stall, characters of the next string keep
// flowing; only a further final character waits in the request register, and
// req_stall is then raised until the result register frees.
// A synchronous reset empties both registers, clears the string state and
// sets the base back to detection.
`include "assert_macros.svh"

module string_to_unsigned_integer_parser #(
   parameter int MAX_LEN = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  stup_pkg::req_type              req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output stup_pkg::rsp_type              rsp_payload,
   input  logic                           csr_write,
   input  logic [stup_pkg::BaseWidth-1:0] csr_data
);

   localparam int CW = $clog2(MAX_LEN + 1);

   stup_pkg::req_type               in_ff,       in_in;
   logic                            in_valid_ff, in_valid_in;
   stup_pkg::parse_state_type       st_ff,       st_in;
   logic [CW-1:0]                   cnt_ff,      cnt_in;
   logic [CW-1:0]                   nend_ff,     nend_in;
   logic [stup_pkg::BaseWidth-1:0]  base_ff,     base_in;
   stup_pkg::rsp_type               rsp_ff,      rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   stup_pkg::parse_state_type       step_state;
   logic [CW-1:0]                   step_count;
   logic [CW-1:0]                   step_end;
   stup_pkg::rsp_type               step_result;
   logic                            out_free;
   logic                            advance;
   logic                            take;

   stup_step #(
      .MAX_LEN (MAX_LEN)
   ) u_step (
      .cur_state  (st_ff),
      .cur_count  (cnt_ff),
      .cur_end    (nend_ff),
      .cfg_base   (base_ff),
      .req        (in_ff),
      .next_state (step_state),
      .next_count (step_count),
      .next_end   (step_end),
      .result     (step_result)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_ff.last || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = take || (in_valid_ff && !advance);
      in_in        = take ? req_payload : in_ff;
      st_in        = advance ? step_state : st_ff;
      cnt_in       = advance ? step_count : cnt_ff;
      nend_in      = advance ? step_end : nend_ff;
      base_in      = csr_write ? csr_data : base_ff;
      rsp_valid_in = (advance && in_ff.last) || (rsp_valid_ff && rsp_stall);
      rsp_in       = (advance && in_ff.last) ? step_result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= stup_pkg::IdleState;
         cnt_ff       <= '0;
         nend_ff      <= '0;
         base_ff      <= stup_pkg::BaseDetect;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         nend_ff      <= nend_in;
         base_ff      <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `CHECK_IMP(a_range_saturates, rsp_valid_ff && rsp_ff.range_error, &rsp_ff.value)
   `CHECK_IMP(a_stall_only_on_full_out, req_stall,
              in_valid_ff && in_ff.last && rsp_valid_ff && rsp_stall)
   `CHECK_NEXT(a_string_closes, advance && in_ff.last,
               cnt_ff == '0 && nend_ff == '0 && st_ff.phase == stup_pkg::PH_WS)
   `CHECK_IMP(a_end_within_count, 1'b1, nend_ff <= cnt_ff)

endmodule

>>> sv/stup_step.sv
// per-character parse step: next string state and the result of a closing character
module stup_step #(
   parameter int MAX_LEN = 4096
) (
   input  stup_pkg::parse_state_type           cur_state,
   input  logic [$clog2(MAX_LEN+1)-1:0]         cur_count,
   input  logic [$clog2(MAX_LEN+1)-1:0]         cur_end,
   input  logic [stup_pkg::BaseWidth-1:0]       cfg_base,
   input  stup_pkg::req_type                    req,
   output stup_pkg::parse_state_type           next_state,
   output logic [$clog2(MAX_LEN+1)-1:0]         next_count,
   output logic [$clog2(MAX_LEN+1)-1:0]         next_end,
   output stup_pkg::rsp_type                    result
);

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int EW = (CW > stup_pkg::ConsumedWidth) ? CW : stup_pkg::ConsumedWidth;
   localparam int PW = stup_pkg::ValueWidth + stup_pkg::BaseWidth + 1;

   stup_pkg::parse_state_type st;
   logic [CW-1:0]                   cnt;
   logic [CW-1:0]                   nend;
   logic                            proc;
   logic                            take;
   logic [stup_pkg::BaseWidth-1:0]  dig;
   logic [PW-1:0]                   prod;
   logic [EW-1:0]                   end_ext;

   always_comb begin
      st   = cur_state;
      nend = cur_end;
      proc = 1'b0;
      take = 1'b0;
      dig  = stup_pkg::digit_value(req.ch);
      prod = '0;

      // first character of a string latches the base
      if (cur_count == '0) begin
         st.base_in_use = cfg_base;
         st.phase = (cfg_base == stup_pkg::BaseOne || cfg_base > stup_pkg::BaseMax) ?
                    stup_pkg::PH_DONE : stup_pkg::PH_WS;
      end
      cnt = (cur_count < CW'(MAX_LEN)) ? cur_count + CW'(1) : cur_count;

      case (st.phase)
         stup_pkg::PH_WS: begin
            if (stup_pkg::is_space(req.ch)) begin
               st.phase = stup_pkg::PH_WS;
            end else if (req.ch == stup_pkg::ChMinus) begin
               st.minus_seen = 1'b1;
               st.phase = stup_pkg::PH_FIRST;
            end else if (req.ch == stup_pkg::ChPlus) begin
               st.phase = stup_pkg::PH_FIRST;
            end else begin
               st.phase = stup_pkg::PH_FIRST;
               proc = 1'b1;
            end
         end
         stup_pkg::PH_FIRST, stup_pkg::PH_ZERO, stup_pkg::PH_X, stup_pkg::PH_DIG: begin
            proc = 1'b1;
         end
         default: begin
            proc = 1'b0;
         end
      endcase

      if (proc) begin
         case (st.phase)
            stup_pkg::PH_FIRST: begin
               if (req.ch == stup_pkg::ChZero && (st.base_in_use == stup_pkg::BaseDetect ||
                   st.base_in_use == stup_pkg::BaseHex)) begin
                  st.acc = '0;
                  nend = cnt;
                  st.phase = stup_pkg::PH_ZERO;
               end else begin
                  if (st.base_in_use == stup_pkg::BaseDetect) begin
                     st.base_in_use = stup_pkg::BaseDec;
                  end
                  take = 1'b1;
               end
            end
            stup_pkg::PH_ZERO: begin
               if (req.ch == stup_pkg::ChLowX || req.ch == stup_pkg::ChUpX) begin
                  st.base_in_use = stup_pkg::BaseHex;
                  st.phase = stup_pkg::PH_X;
               end else begin
                  st.base_in_use = (st.base_in_use == stup_pkg::BaseDetect) ?
                                   stup_pkg::BaseOct : stup_pkg::BaseHex;
                  take = 1'b1;
               end
            end
            stup_pkg::PH_X, stup_pkg::PH_DIG: begin
               take = 1'b1;
            end
            default: begin
               take = 1'b0;
            end
         endcase
      end

      // multiply-add by the base; carry out of 64 bits is overflow
      if (take) begin
         if (dig >= st.base_in_use || st.base_in_use < stup_pkg::BaseMin) begin
            st.phase = stup_pkg::PH_DONE;
         end else begin
            prod = PW'(st.acc) * PW'(st.base_in_use) + PW'(dig);
            if (!st.overflowed) begin
               if (prod[PW-1:stup_pkg::ValueWidth] != '0) begin
                  st.overflowed = 1'b1;
               end else begin
                  st.acc = prod[stup_pkg::ValueWidth-1:0];
               end
            end
            nend = cnt;
            st.phase = stup_pkg::PH_DIG;
         end
      end

      end_ext = EW'(nend);
      result.range_error = st.overflowed;
      result.consumed    = end_ext[stup_pkg::ConsumedWidth-1:0];
      if (st.overflowed) begin
         result.value = '1;
      end else if (st.minus_seen) begin
         result.value = '0 - st.acc;
      end else begin
         result.value = st.acc;
      end

      // closing character returns the string state to idle
      if (req.last) begin
         next_state = stup_pkg::IdleState;
         next_count = '0;
         next_end   = '0;
      end else begin
         next_state = st;
         next_count = cnt;
         next_end   = nend;
      end
   end

endmodule

>>> bench/parse_result_checker.sv
// checker of the string to integer parser: predicts each result and compares it on the rsp_ side
module parse_result_checker #(
   parameter int MAX_LEN = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  stup_pkg::req_type              req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  stup_pkg::rsp_type              rsp_payload,
   input  logic                           csr_write,
   input  logic [stup_pkg::BaseWidth-1:0] csr_data,
   output int                             mismatches,
   output int                             outstanding
);
   import stup_pkg::*;

   rsp_type              conversions_due[$];
   logic [BaseWidth-1:0] base_reg;
   phase_type            phase;
   logic [63:0]          acc;
   logic                 minus_seen;
   logic                 overflowed;
   logic [BaseWidth-1:0] cur_base;
   int                   char_count;
   int                   number_end;
   int                   errors = 0;

   function automatic logic [BaseWidth-1:0] char_digit(input logic [7:0] c);
      if (c >= ChZero && c <= ChNine) return BaseWidth'(c - ChZero);
      if (c >= ChUpA && c <= ChUpZ) return BaseWidth'(c - ChUpA + 8'd10);
      if (c >= ChLowA && c <= ChLowZ) return BaseWidth'(c - ChLowA + 8'd10);
      return NoDigit;
   endfunction

   function automatic logic blank(input logic [7:0] c);
      return c == ChSpace || (c >= ChTab && c <= ChCr);
   endfunction

   task automatic restart_string();
      phase      = PH_WS;
      acc        = '0;
      minus_seen = 1'b0;
      overflowed = 1'b0;
      cur_base   = BaseDetect;
      char_count = 0;
      number_end = 0;
   endtask

   task automatic accept_digit(input logic [7:0] c);
      logic [BaseWidth-1:0] d;
      logic [70:0]          wide;
      d = char_digit(c);
      if (d >= cur_base || cur_base < BaseMin) begin
         phase = PH_DONE;
         return;
      end
      wide = 71'(acc) * 71'(cur_base) + 71'(d);
      if (!overflowed) begin
         if (wide[70:64] != '0) begin
            overflowed = 1'b1;
         end else begin
            acc = wide[63:0];
         end
      end
      number_end = char_count;
      phase = PH_DIG;
   endtask

   task automatic parse_char(input logic [7:0] c, input logic last);
      logic    go;
      rsp_type res;
      if (char_count == 0) begin
         cur_base = base_reg;
         phase = (base_reg == BaseOne || base_reg > BaseMax) ? PH_DONE : PH_WS;
      end
      if (char_count < MAX_LEN) char_count++;
      go = (phase != PH_WS);
      if (phase == PH_WS) begin
         if (blank(c)) begin
         end else if (c == ChMinus) begin
            minus_seen = 1'b1;
            phase = PH_FIRST;
         end else if (c == ChPlus) begin
            phase = PH_FIRST;
         end else begin
            phase = PH_FIRST;
            go = 1'b1;
         end
      end
      if (go) begin
         case (phase)
            PH_FIRST: begin
               if (c == ChZero && (cur_base == BaseDetect || cur_base == BaseHex)) begin
                  acc = '0;
                  number_end = char_count;
                  phase = PH_ZERO;
               end else begin
                  if (cur_base == BaseDetect) cur_base = BaseDec;
                  accept_digit(c);
               end
            end
            PH_ZERO: begin
               if (c == ChLowX || c == ChUpX) begin
                  cur_base = BaseHex;
                  phase = PH_X;
               end else begin
                  cur_base = (cur_base == BaseDetect) ? BaseOct : BaseHex;
                  accept_digit(c);
               end
            end
            PH_X, PH_DIG: accept_digit(c);
            default: ;
         endcase
      end
      if (last) begin
         if (overflowed) res.value = '1;
         else if (minus_seen) res.value = 64'd0 - acc;
         else res.value = acc;
         res.range_error = overflowed;
         res.consumed = ConsumedWidth'(number_end);
         conversions_due.push_back(res);
         restart_string();
      end
   endtask

   task automatic compare_result(input rsp_type got);
      rsp_type want;
      if (conversions_due.size() == 0) begin
         errors++;
         $display("%0t: unexpected result, expected none, actual value %h error %b consumed %0d",
                  $time, got.value, got.range_error, got.consumed);
         return;
      end
      want = conversions_due.pop_front();
      if (got.value !== want.value) begin
         errors++;
         $display("%0t: value mismatch, expected %h actual %h", $time, want.value, got.value);
      end
      if (got.range_error !== want.range_error) begin
         errors++;
         $display("%0t: range_error mismatch, expected %b actual %b",
                  $time, want.range_error, got.range_error);
      end
      if (got.consumed !== want.consumed) begin
         errors++;
         $display("%0t: consumed mismatch, expected %0d actual %0d",
                  $time, want.consumed, got.consumed);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         base_reg = BaseDetect;
         restart_string();
         conversions_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) compare_result(rsp_payload);
         if (csr_write) base_reg = csr_data;
         if (req_valid && !req_stall) parse_char(req_payload.ch, req_payload.last);
      end
      mismatches  <= errors;
      outstanding <= conversions_due.size();
   end

endmodule

>>> bench/tb.sv
// testbench top of the string to integer parser: stimulus, stall patterns and verdict
module tb;
   import stup_pkg::*;

   localparam int MaxLen = 4096;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_write   = 1'b0;
   logic [BaseWidth-1:0] csr_data    = BaseDetect;
   int                   mismatches;
   int                   outstanding;
   int                   hold_asks   = 0;

   logic [7:0] text[$];
   int         burst_left = 0;
   logic       steady     = 1'b0;

   string_to_unsigned_integer_parser #(.MAX_LEN(MaxLen)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_data    (csr_data)
   );

   parse_result_checker #(.MAX_LEN(MaxLen)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

   // receiver stalls in segments, with one long hold-off on request
   initial begin
      int seg;
      int mode;
      int served;
      served = 0;
      do @(posedge clock); while (reset);
      forever begin
         seg  = $urandom_range(1, 64);
         mode = $urandom_range(0, 3);
         repeat (seg) begin
            @(posedge clock);
            if (hold_asks != served) begin
               served = hold_asks;
               rsp_stall <= 1'b1;
               repeat (150) @(posedge clock);
            end
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   task automatic send_char(input logic [7:0] c, input logic l);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = steady ? 0 : $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= '{ch: c, last: l};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_base(input logic [BaseWidth-1:0] b);
      csr_write <= 1'b1;
      csr_data  <= b;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [7:0] blank_char();
      return ($urandom_range(0, 5) == 0) ? ChSpace : ChTab + 8'($urandom_range(0, 4));
   endfunction

   function automatic logic [7:0] digit_char(input int v);
      if (v < 10) return ChZero + 8'(v);
      return ($urandom_range(0, 1) ? ChUpA : ChLowA) + 8'(v - 10);
   endfunction

   task automatic build_text(input logic [BaseWidth-1:0] b);
      int   kind;
      int   n;
      int   i;
      int   v;
      logic maxed;
      logic [BaseWidth-1:0] eff;
      text.delete();
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
         n = $urandom_range(1, 6);
         repeat (n) text.push_back(8'($urandom_range(0, 255)));
         return;
      end
      repeat ($urandom_range(0, 2)) text.push_back(blank_char());
      case ($urandom_range(0, 3))
         0:       text.push_back(ChMinus);
         1:       text.push_back(ChPlus);
         default: ;
      endcase
      if (kind == 8) begin
         case ($urandom_range(0, 2))
            0: text.push_back($urandom_range(0, 1) ? ChPlus : ChMinus);
            1: begin
               text.push_back(ChZero);
               text.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
               text.push_back(blank_char());
            end
            default: ;
         endcase
         if (text.size() == 0) text.push_back(ChSpace);
         return;
      end
      eff = b;
      if (b == BaseDetect) begin
         case ($urandom_range(0, 2))
            0: eff = BaseDec;
            1: begin
               eff = BaseOct;
               text.push_back(ChZero);
            end
            default: begin
               eff = BaseHex;
               text.push_back(ChZero);
               text.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
            end
         endcase
      end else if (b == BaseHex && $urandom_range(0, 1)) begin
         text.push_back(ChZero);
         text.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
      end else if (b == BaseOne || b > BaseMax) begin
         eff = BaseDec;
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: n = $urandom_range(1, 6);
         6, 7:             n = $urandom_range(7, 20);
         default:          n = $urandom_range(18, 70);
      endcase
      maxed = ($urandom_range(0, 9) == 0);
      for (i = 0; i < n; i++) begin
         v = maxed ? int'(eff) - 1 : $urandom_range(0, int'(eff) - 1);
         text.push_back(digit_char(v));
      end
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_phase(input logic [BaseWidth-1:0] b, input int budget, input logic hold);
      int sent;
      settle();
      write_base(b);
      steady = ($urandom_range(0, 3) == 0);
      if (hold) hold_asks <= hold_asks + 1;
      sent = 0;
      while (sent < budget) begin
         build_text(b);
         send_text();
         sent += text.size();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // base detection straight after reset
      text = '{ChTab, ChPlus, ChZero, ChLowX, ChLowA + 8'd6};
      send_text();
      text = '{ChMinus, ChZero + 8'd1, ChZero + 8'd7};
      send_text();
      text = '{ChZero, ChZero + 8'd7, ChZero + 8'd8};
      send_text();
      text = '{8'hff};
      send_text();
      text = '{8'h00};
      send_text();
      text = '{ChCr, ChSpace, ChZero, ChUpX, ChUpA + 8'd5, ChLowA + 8'd5};
      send_text();

      run_phase(BaseDec, 45, 1'b1);
      run_phase(BaseHex, 45, 1'b0);
      run_phase(BaseOct, 45, 1'b0);
      run_phase(BaseMin, 45, 1'b0);
      run_phase(BaseMax, 45, 1'b0);
      run_phase(BaseOne, 12, 1'b0);
      run_phase(6'd37, 12, 1'b0);
      run_phase(6'h3f, 12, 1'b0);
      run_phase(BaseDetect, 45, 1'b0);
      run_phase(BaseWidth'($urandom_range(2, 36)), 45, 1'b0);
      run_phase(BaseWidth'($urandom_range(2, 36)), 45, 1'b0);
      run_phase(BaseWidth'($urandom_range(0, 63)), 45, 1'b0);

      // long run of leading zeros
      settle();
      write_base(BaseDec);
      text.delete();
      repeat (24) text.push_back(ChZero);
      text.push_back(ChZero + 8'd1);
      send_text();

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
